[rtl/vlos_pkg.sv]
// ----------------------------------------------------------------------------
// vlos_pkg
// Shared types and constants of the voxel line-of-sight block.
// ----------------------------------------------------------------------------
package vlos_pkg;

    localparam int COORD_W     = 32;
    localparam int ORIGIN_W    = 16;
    localparam int EXTENT_W    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ADDR_IN_W   = 15;
    localparam int COUNT_OUT_W = 7;
    localparam int T_FRAC      = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_AXIS,
        ST_DIV_STEP,
        ST_DIV_PARAM,
        ST_CHECK,
        ST_INDEX,
        ST_DECIDE,
        ST_FINISH
    } state_t;

endpackage

[rtl/vlos_if.sv]
// ----------------------------------------------------------------------------
// vlos_in_if / vlos_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface vlos_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [14:0] mask_address;
    logic        mask_bit;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (
        output valid, command, mask_address, mask_bit,
        output start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, command, mask_address, mask_bit,
        input  start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

interface vlos_out_if;
    logic       valid;
    logic       ready;
    logic       visible;
    logic [6:0] voxels_checked;

    modport source (output valid, visible, voxels_checked, input ready);
    modport sink   (input valid, visible, voxels_checked, output ready);
endinterface

[rtl/voxel_line_of_sight_dda_core.sv]
// ----------------------------------------------------------------------------
// voxel_line_of_sight_dda_core
// Line-of-sight queries through a one-bit voxel mask with a 3D DDA walk.
// ----------------------------------------------------------------------------
// After reset the mask memory is cleared one entry a cycle, and no beat is
// taken until the sweep ends. A write beat goes from idle straight to the
// finish state. A query has a setup state, then per axis an axis setup state
// and, for a moving axis, two divisions on the shared serial divider (the
// reciprocal step and the first crossing), then per voxel walked the check
// state (region test and row product), the index state (index product and
// memory read) and the decide state (axis choice and step). One item is in
// work at a time; a finished result waits in the output register while the
// next beat is taken.
// ----------------------------------------------------------------------------
module voxel_line_of_sight_dda_core
    import vlos_pkg::*;
#(
    parameter int MAX_EXTENT  = 32,
    parameter int STORE_DEPTH = 32768,
    parameter int FRAC_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vlos_in_if.sink               in_ch,
    vlos_out_if.source            out_ch
);

    localparam int T_BITS     = FRAC_BITS + T_FRAC;
    localparam int QW         = T_BITS + 1;
    localparam int MAG_W      = 34;
    localparam int VW         = 34 - FRAC_BITS;
    localparam int LW         = (VW > ORIGIN_W ? VW : ORIGIN_W) + 1;
    localparam int AW         = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
    localparam int IW         = AW > 19 ? AW : 19;
    localparam int WALK_LIMIT = 3 * MAX_EXTENT + 3;
    localparam int CW0        = $clog2(WALK_LIMIT + 1);
    localparam int CW         = CW0 > COUNT_OUT_W ? CW0 : COUNT_OUT_W;
    localparam int PW         = 13;
    localparam logic [T_BITS-1:0] T_CAP = {T_BITS{1'b1}};
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC;

    // configuration
    logic signed [ORIGIN_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [EXTENT_W-1:0]        exw_reg, eyw_reg, ezw_reg;
    logic [EXTENT_W-1:0]        ex_c, ey_c, ez_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg  <= '0;
            oy_reg  <= '0;
            oz_reg  <= '0;
            exw_reg <= '0;
            eyw_reg <= '0;
            ezw_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: ox_reg  <= cfg_data;
                CFG_ORIGIN_Y: oy_reg  <= cfg_data;
                CFG_ORIGIN_Z: oz_reg  <= cfg_data;
                CFG_EXTENT_X: exw_reg <= cfg_data[EXTENT_W-1:0];
                CFG_EXTENT_Y: eyw_reg <= cfg_data[EXTENT_W-1:0];
                CFG_EXTENT_Z: ezw_reg <= cfg_data[EXTENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ex_c = (32'(exw_reg) > MAX_EXTENT) ? EXTENT_W'(MAX_EXTENT) : exw_reg;
        ey_c = (32'(eyw_reg) > MAX_EXTENT) ? EXTENT_W'(MAX_EXTENT) : eyw_reg;
        ez_c = (32'(ezw_reg) > MAX_EXTENT) ? EXTENT_W'(MAX_EXTENT) : ezw_reg;
    end

    // sequencer state
    state_t                     state_reg, state_next;
    logic [1:0]                 axis_reg, axis_next;
    logic signed [COORD_W-1:0]  s_reg [3];
    logic signed [COORD_W-1:0]  s_next [3];
    logic signed [COORD_W-1:0]  e_reg [3];
    logic signed [COORD_W-1:0]  e_next [3];
    logic signed [VW-1:0]       vox_reg [3];
    logic signed [VW-1:0]       vox_next [3];
    logic signed [1:0]          sg_reg [3];
    logic signed [1:0]          sg_next [3];
    logic [T_BITS-1:0]          par_reg [3];
    logic [T_BITS-1:0]          par_next [3];
    logic [T_BITS-1:0]          stp_reg [3];
    logic [T_BITS-1:0]          stp_next [3];
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic [FRAC_BITS:0]         dist_reg, dist_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [PW-1:0]              part_reg, part_next;
    logic [EXTENT_W-1:0]        lx_reg, lx_next;
    logic                       inrange_reg, inrange_next;
    logic                       res_vis_reg, res_vis_next;
    logic [CW-1:0]              res_cnt_reg, res_cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_vis_reg, out_vis_next;
    logic [COUNT_OUT_W-1:0]     out_cnt_reg, out_cnt_next;

    // per-axis setup
    logic signed [COORD_W-1:0] s_a, e_a;
    logic signed [COORD_W:0]   d_a;
    logic [COORD_W:0]          absd_a;
    logic signed [1:0]         sg_a;
    logic signed [MAG_W-1:0]   fa_a;
    logic [MAG_W-1:0]          mag_a;
    logic [FRAC_BITS-1:0]      fr_a;
    logic [FRAC_BITS:0]        dist_a;

    // walk
    logic signed [LW-1:0] lx, ly, lz;
    logic                 in_region;
    logic [IW-1:0]        idx;
    logic [T_BITS-1:0]    px, py, pz;
    logic [1:0]           sel;
    logic [T_BITS:0]      sum;
    logic [T_BITS-1:0]    sat;
    logic                 all_past;

    // shared units
    logic          div_start;
    logic [QW-1:0] div_dividend;
    logic [MAG_W-1:0] div_divisor;
    logic          div_done;
    logic [QW-1:0] div_quo;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;
    logic          ram_ready;
    logic          in_beat;

    vlos_div #(
        .QW (QW),
        .DW (MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    vlos_mask_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ch.mask_bit),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .ready (ram_ready)
    );

    assign in_ch.ready = (state_reg == ST_IDLE) && ram_ready;
    assign in_beat     = in_ch.valid && in_ch.ready;
    assign ram_waddr   = AW'(in_ch.mask_address);
    assign ram_we      = in_beat && (in_ch.command == CMD_WRITE)
                         && (26'(in_ch.mask_address) < 26'(STORE_DEPTH));

    always_comb
    begin
        s_a    = s_reg[axis_reg];
        e_a    = e_reg[axis_reg];
        d_a    = {e_a[COORD_W-1], e_a} - {s_a[COORD_W-1], s_a};
        sg_a   = d_a[COORD_W] ? -2'sd1 : ((d_a != '0) ? 2'sd1 : 2'sd0);
        fa_a   = {{2{s_a[COORD_W-1]}}, s_a} - {{(MAG_W-2){sg_a[1]}}, sg_a};
        absd_a = d_a[COORD_W] ? $unsigned(-d_a) : $unsigned(d_a);
        mag_a  = {1'b0, absd_a} + MAG_W'(2);
        fr_a   = fa_a[FRAC_BITS-1:0];
        dist_a = sg_a[1] ? {1'b0, fr_a}
                         : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fr_a});
    end

    always_comb
    begin
        lx        = LW'(vox_reg[0]) - LW'(ox_reg);
        ly        = LW'(vox_reg[1]) - LW'(oy_reg);
        lz        = LW'(vox_reg[2]) - LW'(oz_reg);
        in_region = !lx[LW-1] && ($unsigned(lx) < LW'(ex_c))
                 && !ly[LW-1] && ($unsigned(ly) < LW'(ey_c))
                 && !lz[LW-1] && ($unsigned(lz) < LW'(ez_c));
        idx       = IW'(part_reg) * IW'(ex_c) + IW'(lx_reg);
        px        = par_reg[0];
        py        = par_reg[1];
        pz        = par_reg[2];
        all_past  = (px > T_ONE) && (py > T_ONE) && (pz > T_ONE);
        if (px < py)
        begin
            sel = (px < pz) ? AXIS_X : AXIS_Z;
        end
        else
        begin
            sel = (py < pz) ? AXIS_Y : AXIS_Z;
        end
        sum = {1'b0, par_reg[sel]} + {1'b0, stp_reg[sel]};
        sat = sum[T_BITS] ? T_CAP : sum[T_BITS-1:0];
    end

    assign ram_raddr = idx[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        vox_next       = vox_reg;
        sg_next        = sg_reg;
        par_next       = par_reg;
        stp_next       = stp_reg;
        mag_next       = mag_reg;
        dist_next      = dist_reg;
        count_next     = count_reg;
        part_next      = part_reg;
        lx_next        = lx_reg;
        inrange_next   = inrange_reg;
        res_vis_next   = res_vis_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg;
        out_vis_next   = out_vis_reg;
        out_cnt_next   = out_cnt_reg;
        div_start      = 1'b0;
        div_dividend   = {1'b1, {T_BITS{1'b0}}};
        div_divisor    = mag_a;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    s_next[0]    = in_ch.start_x;
                    s_next[1]    = in_ch.start_y;
                    s_next[2]    = in_ch.start_z;
                    e_next[0]    = in_ch.end_x;
                    e_next[1]    = in_ch.end_y;
                    e_next[2]    = in_ch.end_z;
                    res_vis_next = 1'b0;
                    res_cnt_next = '0;
                    state_next   = (in_ch.command == CMD_QUERY) ? ST_PREP : ST_FINISH;
                end
            end
            ST_PREP:
            begin
                axis_next = AXIS_X;
                if (ex_c == '0 || ey_c == '0 || ez_c == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (s_reg[0] == e_reg[0] && s_reg[1] == e_reg[1]
                         && s_reg[2] == e_reg[2])
                begin
                    res_vis_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                vox_next[axis_reg] = fa_a[MAG_W-1:FRAC_BITS];
                sg_next[axis_reg]  = sg_a;
                mag_next           = mag_a;
                dist_next          = dist_a;
                if (sg_a == 2'sd0)
                begin
                    par_next[axis_reg] = T_CAP;
                    stp_next[axis_reg] = T_CAP;
                    if (axis_reg == AXIS_Z)
                    begin
                        count_next = '0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_STEP;
                end
            end
            ST_DIV_STEP:
            begin
                if (div_done)
                begin
                    stp_next[axis_reg] = div_quo[T_BITS-1:0];
                    div_start          = 1'b1;
                    div_dividend       = {dist_reg, {T_FRAC{1'b0}}};
                    div_divisor        = mag_reg;
                    state_next         = ST_DIV_PARAM;
                end
            end
            ST_DIV_PARAM:
            begin
                if (div_done)
                begin
                    par_next[axis_reg] = div_quo[T_BITS-1:0];
                    if (axis_reg == AXIS_Z)
                    begin
                        count_next = '0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_AXIS;
                    end
                end
            end
            ST_CHECK:
            begin
                if (count_reg == CW'(WALK_LIMIT) || !in_region)
                begin
                    res_vis_next = 1'b0;
                    res_cnt_next = count_reg;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    part_next  = PW'(ly[EXTENT_W-1:0]) * PW'(ez_c)
                               + PW'(lz[EXTENT_W-1:0]);
                    lx_next    = lx[EXTENT_W-1:0];
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                inrange_next = 26'(idx) < 26'(STORE_DEPTH);
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (ram_rdata && inrange_reg)
                begin
                    res_vis_next = 1'b0;
                    res_cnt_next = count_reg;
                    state_next   = ST_FINISH;
                end
                else if (all_past)
                begin
                    res_vis_next = 1'b1;
                    res_cnt_next = count_reg;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    vox_next[sel] = vox_reg[sel] + VW'(sg_reg[sel]);
                    par_next[sel] = sat;
                    state_next    = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_vis_next   = res_vis_reg;
                    out_cnt_next   = res_cnt_reg[COUNT_OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        e_reg       <= e_next;
        vox_reg     <= vox_next;
        sg_reg      <= sg_next;
        par_reg     <= par_next;
        stp_reg     <= stp_next;
        mag_reg     <= mag_next;
        dist_reg    <= dist_next;
        part_reg    <= part_next;
        lx_reg      <= lx_next;
        inrange_reg <= inrange_next;
        res_vis_reg <= res_vis_next;
        res_cnt_reg <= res_cnt_next;
        out_vis_reg <= out_vis_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.visible        = out_vis_reg;
    assign out_ch.voxels_checked = out_cnt_reg;

endmodule

[rtl/vlos_div.sv]
// ----------------------------------------------------------------------------
// vlos_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vlos_div #(
    parameter int QW = 49,
    parameter int DW = 34
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   rem_next;
    logic [QW-1:0]   quo_reg;
    logic [DW-1:0]   dsr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic            ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[QW-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? DW'(trial - {1'b0, dsr_reg}) : DW'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsr_reg  <= divisor;
            cnt_reg  <= CNTW'(QW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[QW-2:0], ge};
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNTW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/vlos_mask_ram.sv]
// ----------------------------------------------------------------------------
// vlos_mask_ram
// One-bit solid mask memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module vlos_mask_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata,
    output logic          ready
);

    logic          mem [DEPTH];
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;
    logic          rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

[rtl/vlos_checker.sv]
// ----------------------------------------------------------------------------
// vlos_checker
// Port-level checks of the line-of-sight core, bound to the top level.
// ----------------------------------------------------------------------------
module vlos_checker #(
    parameter int MAX_EXTENT = 32
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_visible,
    input logic [6:0] out_voxels_checked
);

    localparam int WALK_LIMIT = 3 * MAX_EXTENT + 3;

    // one item in work at a time
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // no result appears in the cycle after a beat is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result shown before the item was worked");

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_visible)
                                       && $stable(out_voxels_checked)))
        else $error("stalled result beat changed");

    // count never runs past the walk limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_voxels_checked) <= WALK_LIMIT))
        else $error("voxel count beyond walk limit");

endmodule

bind voxel_line_of_sight_dda_core vlos_checker #(
    .MAX_EXTENT (MAX_EXTENT)
) u_vlos_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_visible        (out_ch.visible),
    .out_voxels_checked (out_ch.voxels_checked)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for voxel_line_of_sight_dda_core: mask writes and
// line-of-sight queries are driven over valid/ready channels, every result
// beat is compared with a typed result or an in-bench voxel walk model, with
// directed corner cases first and then random regions, masks and rays under varied idling.
// ----------------------------------------------------------------------------
module testbench;
    import vlos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MASK_DEPTH   = 32768;
    localparam int EXTENT_LIMIT = 32;
    localparam int WALK_CAP     = 3 * EXTENT_LIMIT + 3;
    localparam int RANDOM_ITEMS = 900;
    localparam longint unsigned PARAM_MAX = (64'd1 << 48) - 1;
    localparam longint unsigned PARAM_ONE = 64'd1 << T_FRAC;

    typedef struct {
        logic              command;
        logic [14:0]       mask_address;
        logic              mask_bit;
        logic signed [31:0] s [3];
        logic signed [31:0] e [3];
    } cmd_beat_t;

    typedef struct {
        logic       visible;
        logic [6:0] voxels_checked;
    } sight_t;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [15:0]          reg_value;
        cmd_beat_t            beat;
        bit                   typed;
        sight_t               result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vlos_in_if  in_ch ();
    vlos_out_if out_ch ();

    voxel_line_of_sight_dda_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    bit              model_mask [MASK_DEPTH];
    logic [15:0]     region_origin [3];
    logic [5:0]      region_extent [3];
    sight_t          pending_sight [$];
    stim_row_t       directed_rows [$];
    int              error_count;
    int              query_count;
    int              sight_count;
    int              write_count;
    int              result_count;
    int              sender_gap_pct;
    int              receiver_stall_pct;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #100ms;
        $display("** voxel_line_of_sight_dda_core: FAILED **");
        $finish;
    end

    function automatic longint clamp_size(logic [5:0] e);
        return (e > EXTENT_LIMIT) ? EXTENT_LIMIT : longint'(e);
    endfunction

    function automatic sight_t walk_ray(cmd_beat_t b);
        sight_t          r;
        longint          ext [3];
        longint          org [3];
        longint          sv [3];
        longint          ev [3];
        longint          sg [3];
        longint          cell_pos [3];
        longint          d, fa, span, idx, lx, ly, lz;
        longint unsigned fr, lead, mag, sum;
        longint unsigned par [3];
        longint unsigned stp [3];
        int              ax;
        r.visible = 1'b0;
        r.voxels_checked = '0;
        if (b.command == CMD_WRITE)
        begin
            model_mask[b.mask_address] = b.mask_bit;
            return r;
        end
        for (int a = 0; a < 3; a++)
        begin
            ext[a] = clamp_size(region_extent[a]);
            org[a] = longint'($signed(region_origin[a]));
            sv[a] = longint'(b.s[a]);
            ev[a] = longint'(b.e[a]);
        end
        if (ext[0] == 0 || ext[1] == 0 || ext[2] == 0)
            return r;
        if (sv[0] == ev[0] && sv[1] == ev[1] && sv[2] == ev[2])
        begin
            r.visible = 1'b1;
            return r;
        end
        for (int a = 0; a < 3; a++)
        begin
            d = ev[a] - sv[a];
            sg[a] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
            fa = sv[a] - sg[a];
            span = ev[a] + sg[a] - fa;
            cell_pos[a] = fa >>> 16;
            fr = longint'(fa & 64'hffff);
            if (sg[a] == 0)
            begin
                par[a] = PARAM_MAX;
                stp[a] = PARAM_MAX;
            end
            else
            begin
                mag = (span < 0) ? -span : span;
                lead = (sg[a] > 0) ? (64'd65536 - fr) : fr;
                stp[a] = (64'd1 << 48) / mag;
                par[a] = (lead << T_FRAC) / mag;
            end
        end
        for (int it = 0; it < WALK_CAP; it++)
        begin
            lx = cell_pos[0] - org[0];
            ly = cell_pos[1] - org[1];
            lz = cell_pos[2] - org[2];
            if (lx < 0 || lx >= ext[0] || ly < 0 || ly >= ext[1] || lz < 0 || lz >= ext[2])
                break;
            r.voxels_checked++;
            idx = (ly * ext[2] + lz) * ext[0] + lx;
            if (idx >= 0 && idx < MASK_DEPTH && model_mask[idx])
                break;
            if (par[0] > PARAM_ONE && par[1] > PARAM_ONE && par[2] > PARAM_ONE)
            begin
                r.visible = 1'b1;
                break;
            end
            if (par[0] < par[1])
                ax = (par[0] < par[2]) ? 0 : 2;
            else
                ax = (par[1] < par[2]) ? 1 : 2;
            cell_pos[ax] += sg[ax];
            sum = par[ax] + stp[ax];
            par[ax] = (sum > PARAM_MAX) ? PARAM_MAX : sum;
        end
        return r;
    endfunction

    // result side: random stall, compare against oldest prediction
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        sight_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            result_count++;
            if (pending_sight.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                error_count++;
            end
            else
            begin
                want = pending_sight.pop_front();
                if (out_ch.visible !== want.visible)
                begin
                    $error("visible: expected %0d, got %0d", want.visible, out_ch.visible);
                    error_count++;
                end
                if (out_ch.voxels_checked !== want.voxels_checked)
                begin
                    $error("voxels_checked: expected %0d, got %0d",
                           want.voxels_checked, out_ch.voxels_checked);
                    error_count++;
                end
            end
        end
    end

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_sight.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx <= CFG_ORIGIN_Z)
            region_origin[idx] = val;
        else
            region_extent[idx - CFG_EXTENT_X] = val[5:0];
    endtask

    task automatic send_beat(cmd_beat_t b, bit typed, sight_t typed_result);
        sight_t model;
        @(negedge clk);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.command = b.command;
        in_ch.mask_address = b.mask_address;
        in_ch.mask_bit = b.mask_bit;
        in_ch.start_x = b.s[0];
        in_ch.start_y = b.s[1];
        in_ch.start_z = b.s[2];
        in_ch.end_x = b.e[0];
        in_ch.end_y = b.e[1];
        in_ch.end_z = b.e[2];
        do
            @(posedge clk);
        while (!in_ch.ready);
        model = walk_ray(b);
        pending_sight.push_back(typed ? typed_result : model);
        if (b.command == CMD_QUERY)
        begin
            query_count++;
            if (model.visible)
                sight_count++;
        end
        else
            write_count++;
    endtask

    function automatic cmd_beat_t make_write(int addr, bit value);
        cmd_beat_t b;
        b.command = CMD_WRITE;
        b.mask_address = addr[14:0];
        b.mask_bit = value;
        for (int a = 0; a < 3; a++)
        begin
            b.s[a] = $urandom;
            b.e[a] = $urandom;
        end
        return b;
    endfunction

    function automatic cmd_beat_t make_ray(int sx, int sy, int sz, int ex, int ey, int ez);
        cmd_beat_t b;
        b.command = CMD_QUERY;
        b.mask_address = 15'($urandom);
        b.mask_bit = 1'($urandom);
        b.s[0] = sx; b.s[1] = sy; b.s[2] = sz;
        b.e[0] = ex; b.e[1] = ey; b.e[2] = ez;
        return b;
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        stim_row_t r;
        r.is_reg = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        r.typed = 1'b0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_beat(cmd_beat_t b, bit typed, bit vis, int cnt);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.beat = b;
        r.typed = typed;
        r.result.visible = vis;
        r.result.voxels_checked = cnt[6:0];
        directed_rows.push_back(r);
    endfunction

    function automatic int ray_coord(int a);
        longint v;
        v = longint'($signed(region_origin[a])) * 65536 - 65536
            + longint'($urandom_range(0, (int'(clamp_size(region_extent[a])) + 2) * 65536));
        if ($urandom_range(3) == 0)
            v = v & ~longint'(64'hffff);
        return int'(v);
    endfunction

    function automatic cmd_beat_t random_query();
        cmd_beat_t b;
        int        pick;
        b = make_ray(ray_coord(0), ray_coord(1), ray_coord(2),
                     ray_coord(0), ray_coord(1), ray_coord(2));
        pick = $urandom_range(15);
        if (pick == 0)
            b.e = b.s;
        else if (pick < 4)
            b.e[pick - 1] = b.s[pick - 1];
        else if (pick == 4)
            for (int a = 0; a < 3; a++)
            begin
                b.s[a] = $urandom;
                b.e[a] = $urandom;
            end
        return b;
    endfunction

    task automatic new_region();
        int pick;
        for (int a = 0; a < 3; a++)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                write_reg(CFG_IDX_W'(CFG_ORIGIN_X + a), 16'h8000);
            else if (pick == 1)
                write_reg(CFG_IDX_W'(CFG_ORIGIN_X + a), 16'h7fff);
            else
                write_reg(CFG_IDX_W'(CFG_ORIGIN_X + a),
                          16'($signed($urandom_range(40)) - 20));
            pick = $urandom_range(39);
            if (pick == 0)
                write_reg(CFG_IDX_W'(CFG_EXTENT_X + a), 16'd0);
            else if (pick == 1)
                write_reg(CFG_IDX_W'(CFG_EXTENT_X + a), 16'd63);
            else if (pick < 6)
                write_reg(CFG_IDX_W'(CFG_EXTENT_X + a), 16'd32);
            else
                write_reg(CFG_IDX_W'(CFG_EXTENT_X + a), 16'($urandom_range(1, 8)));
        end
    endtask

    initial
    begin
        sight_t    none;
        cmd_beat_t b;
        int        sent;
        int        cells;
        int        phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_WRITE;
        in_ch.mask_address = '0;
        in_ch.mask_bit = 1'b0;
        in_ch.start_x = '0;
        in_ch.start_y = '0;
        in_ch.start_z = '0;
        in_ch.end_x = '0;
        in_ch.end_y = '0;
        in_ch.end_z = '0;
        error_count = 0;
        query_count = 0;
        sight_count = 0;
        write_count = 0;
        result_count = 0;
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        none.visible = 1'b0;
        none.voxels_checked = '0;
        for (int a = 0; a < 3; a++)
        begin
            region_origin[a] = '0;
            region_extent[a] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty region after reset, writes return zeros
        add_beat(make_ray(32'h8000, 32'h8000, 32'h8000, 32'h38000, 32'h28000, 32'h18000),
                 1, 0, 0);
        add_beat(make_write(0, 1), 1, 0, 0);
        add_beat(make_write(0, 0), 1, 0, 0);
        add_reg(CFG_EXTENT_X, 16'd4);
        add_reg(CFG_EXTENT_Y, 16'd4);
        add_reg(CFG_EXTENT_Z, 16'd4);
        add_beat(make_ray(32'h18000, 32'h18000, 32'h18000, 32'h18000, 32'h18000, 32'h18000),
                 1, 1, 0);
        add_beat(make_write(0, 1), 1, 0, 0);
        add_beat(make_ray(32'h8000, 32'h8000, 32'h8000, 32'h38000, 32'h38000, 32'h38000),
                 1, 0, 1);
        add_beat(make_write(0, 0), 1, 0, 0);
        add_beat(make_ray(32'h8000, 32'h8000, 32'h8000, 32'h38000, 32'h38000, 32'h38000),
                 0, 0, 0);
        add_beat(make_ray(32'h0, 32'h8000, 32'h8000, 32'h40000, 32'h8000, 32'h8000), 0, 0, 0);
        add_beat(make_ray(32'h3ffff, 32'h30000, 32'h3c000, 32'h0, 32'h0, 32'h0), 0, 0, 0);
        add_beat(make_write(21, 1), 1, 0, 0);
        add_beat(make_ray(32'h8000, 32'h8000, 32'h8000, 32'h38000, 32'h38000, 32'h38000),
                 0, 0, 0);
        add_beat(make_ray(-32'sh8000, 32'h8000, 32'h8000, 32'h28000, 32'h8000, 32'h8000),
                 0, 0, 0);
        add_beat(make_write(32767, 1), 1, 0, 0);
        add_beat(make_write(32767, 0), 1, 0, 0);
        add_reg(CFG_ORIGIN_X, 16'h8000);
        add_reg(CFG_ORIGIN_Y, 16'h8000);
        add_reg(CFG_ORIGIN_Z, 16'h8000);
        add_reg(CFG_EXTENT_X, 16'd63);
        add_reg(CFG_EXTENT_Y, 16'd32);
        add_reg(CFG_EXTENT_Z, 16'd32);
        add_beat(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h801f0000, 32'h801fffff, 32'h800f8000), 0, 0, 0);
        add_beat(make_ray(32'h801fffff, 32'h80000000, 32'h80100000,
                          32'h80000000, 32'h801fffff, 32'h80000000), 0, 0, 0);
        add_beat(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000), 0, 0, 0);
        add_reg(CFG_ORIGIN_X, 16'h7fff);
        add_reg(CFG_ORIGIN_Y, 16'h7fff);
        add_reg(CFG_ORIGIN_Z, 16'h7fff);
        add_beat(make_ray(32'h7fff8000, 32'h7fff8000, 32'h7fff8000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, 0, 0);
        add_beat(make_ray(32'h7fffffff, 32'h7fff0000, 32'h7fff4000,
                          32'h80000000, 32'h80000000, 32'h80000000), 0, 0, 0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                drain();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
                send_beat(directed_rows[i].beat, directed_rows[i].typed,
                          directed_rows[i].result);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_gap_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_gap_pct = 14; receiver_stall_pct = 14; end
            endcase
            drain();
            new_region();
            cells = int'(clamp_size(region_extent[0]) * clamp_size(region_extent[1])
                         * clamp_size(region_extent[2]));
            for (int g = 0; g < 8 && sent < RANDOM_ITEMS; g++)
            begin
                // a few solid or cleared voxels, mostly inside the region, then rays
                for (int k = $urandom_range(1, 6); k > 0; k--)
                begin
                    if ($urandom_range(9) == 0 || cells == 0)
                        b = make_write($urandom_range(32767), 1'($urandom_range(1)));
                    else
                        b = make_write($urandom_range(cells - 1), $urandom_range(3) != 0);
                    send_beat(b, 0, none);
                    sent++;
                end
                for (int k = $urandom_range(2, 8); k > 0; k--)
                begin
                    send_beat(random_query(), 0, none);
                    sent++;
                end
                if (g == 3 && phase == 1)
                    drain();
            end
            phase++;
        end

        drain();
        in_ch.valid = 1'b0;
        repeat (50) @(posedge clk);
        $display("covered %0d mask writes and %0d queries (%0d with sight), %0d results",
                 write_count, query_count, sight_count, result_count);
        $display("directed corners, %0d random regions, four idling mixes", phase);
        if (error_count == 0 && pending_sight.size() == 0)
            $display("** voxel_line_of_sight_dda_core: PASSED **");
        else
            $display("** voxel_line_of_sight_dda_core: FAILED **");
        $finish;
    end

endmodule
